/* design/igmplp_pkg.sv */
// ----------------------------------------------------------------------------
// igmplp_pkg
// Shared types, constants and the type byte decoder for the IGMP message
// length parser.
// ----------------------------------------------------------------------------
package igmplp_pkg;

    typedef logic [2:0] kind_t;

    localparam kind_t KIND_V1    = 3'd0;
    localparam kind_t KIND_V2    = 3'd1;
    localparam kind_t KIND_LEAVE = 3'd2;
    localparam kind_t KIND_QUERY = 3'd3;
    localparam kind_t KIND_V3    = 3'd4;
    localparam kind_t KIND_OTHER = 3'd5;

    localparam logic [7:0] TYPE_V1_REPORT = 8'h12;
    localparam logic [7:0] TYPE_V2_REPORT = 8'h16;
    localparam logic [7:0] TYPE_LEAVE     = 8'h17;
    localparam logic [7:0] TYPE_QUERY     = 8'h11;
    localparam logic [7:0] TYPE_V3_REPORT = 8'h22;

    localparam int POS_W = 17;
    localparam int LEN_W = 16;

    localparam logic [POS_W-1:0] POS_MAX  = {POS_W{1'b1}};
    localparam logic [LEN_W-1:0] LEN_MAX  = {LEN_W{1'b1}};
    localparam logic [LEN_W-1:0] HDR_LEN  = 16'd8;

    // byte positions inside the message
    localparam logic [POS_W-1:0] POS_QCOUNT_HI = 17'd10;
    localparam logic [POS_W-1:0] POS_QCOUNT_LO = 17'd11;
    localparam logic [POS_W-1:0] POS_RCOUNT_HI = 17'd6;
    localparam logic [POS_W-1:0] POS_RCOUNT_LO = 17'd7;
    localparam logic [POS_W-1:0] POS_RECORDS   = 17'd8;

    // byte offsets inside a group record
    localparam logic [POS_W-1:0] OFF_AUX      = 17'd1;
    localparam logic [POS_W-1:0] OFF_NSRC_HI  = 17'd2;
    localparam logic [POS_W-1:0] OFF_NSRC_LO  = 17'd3;

    function automatic kind_t classify(input logic [7:0] type_byte);
        kind_t k;
        case (type_byte)
            TYPE_V1_REPORT: k = KIND_V1;
            TYPE_V2_REPORT: k = KIND_V2;
            TYPE_LEAVE:     k = KIND_LEAVE;
            TYPE_QUERY:     k = KIND_QUERY;
            TYPE_V3_REPORT: k = KIND_V3;
            default:        k = KIND_OTHER;
        endcase
        return k;
    endfunction

endpackage

/* design/igmplp_in_if.sv */
// ----------------------------------------------------------------------------
// igmplp_in_if
// Byte stream channel into the IGMP message length parser.
// ----------------------------------------------------------------------------
interface igmplp_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       msg_start;

    modport source (output valid, output data_byte, output msg_start, input ready);
    modport sink   (input valid, input data_byte, input msg_start, output ready);

endinterface

/* design/igmplp_out_if.sv */
// ----------------------------------------------------------------------------
// igmplp_out_if
// Result channel of the IGMP message length parser.
// ----------------------------------------------------------------------------
interface igmplp_out_if;

    logic                           valid;
    logic                           ready;
    igmplp_pkg::kind_t              msg_kind;
    logic [igmplp_pkg::LEN_W-1:0]   msg_length;
    logic                           length_saturated;

    modport source (output valid, output msg_kind, output msg_length,
                    output length_saturated, input ready);
    modport sink   (input valid, input msg_kind, input msg_length,
                    input length_saturated, output ready);

endinterface

/* design/igmp_message_length_parser_core.sv */
// The byte completing a result passes the byte register, then the result register.
// Throughput: one byte per cycle while the result is not held; the parse update of
// one byte sits between the byte register and the result register.
// A held result does not stop intake until the byte register also fills.
// Reset clears the byte register valid, the parse state and the result valid.
// ----------------------------------------------------------------------------
// igmp_message_length_parser_core
// Walks an IGMP message byte by byte, classifies its type and reports the
// message length (saturated at 65535) once it is known.
// ----------------------------------------------------------------------------
module igmp_message_length_parser_core
(
    input  logic                clk,
    input  logic                rst_n,
    igmplp_in_if.sink           msg,
    igmplp_out_if.source        result
);

    localparam int POS_W = igmplp_pkg::POS_W;
    localparam int LEN_W = igmplp_pkg::LEN_W;

    // byte register
    logic                   stage_valid_reg;
    logic [7:0]             stage_byte_reg;
    logic                   stage_start_reg;

    // parse state
    logic [POS_W-1:0]       byte_pos_reg,     byte_pos_next;
    igmplp_pkg::kind_t      kind_reg,         kind_next;
    logic                   busy_reg,         busy_next;
    logic [15:0]            records_left_reg, records_left_next;
    logic [POS_W-1:0]       record_start_reg, record_start_next;
    logic [7:0]             aux_words_reg,    aux_words_next;
    logic [7:0]             count_high_reg,   count_high_next;
    logic [LEN_W-1:0]       length_sum_reg,   length_sum_next;
    logic                   sat_flag_reg,     sat_flag_next;

    // result register
    logic                   out_valid_reg;
    igmplp_pkg::kind_t      out_kind_reg;
    logic [LEN_W-1:0]       out_length_reg;
    logic                   out_sat_reg;

    logic                   advance;
    logic                   consume;
    logic                   emit;
    logic [POS_W-1:0]       pos_inc;
    logic [POS_W-1:0]       rec_off;
    logic [15:0]            count_word;
    logic [18:0]            add_val;
    logic [19:0]            sum_wide;
    logic [18:0]            rec_size;
    logic [15:0]            records_dec;

    assign advance   = !out_valid_reg || result.ready;
    assign consume   = stage_valid_reg && advance;
    assign msg.ready = !stage_valid_reg || advance;

    assign pos_inc     = (byte_pos_reg != igmplp_pkg::POS_MAX) ?
                         byte_pos_reg + 1'b1 : byte_pos_reg;
    assign rec_off     = pos_inc - record_start_reg;
    assign count_word  = {count_high_reg, stage_byte_reg};
    assign rec_size    = 19'd8 + {9'd0, aux_words_reg, 2'b00} + {1'b0, count_word, 2'b00};
    assign records_dec = records_left_reg - 1'b1;

    // query adds four bytes per source, a v3 record adds its whole size
    assign add_val  = (kind_reg == igmplp_pkg::KIND_QUERY) ?
                      {1'b0, count_word, 2'b00} : rec_size;
    assign sum_wide = {4'd0, length_sum_reg} + {1'b0, add_val};

    always_comb
    begin
        byte_pos_next     = byte_pos_reg;
        kind_next         = kind_reg;
        busy_next         = busy_reg;
        records_left_next = records_left_reg;
        record_start_next = record_start_reg;
        aux_words_next    = aux_words_reg;
        count_high_next   = count_high_reg;
        length_sum_next   = length_sum_reg;
        sat_flag_next     = sat_flag_reg;
        emit              = 1'b0;

        if (consume)
        begin
            if (stage_start_reg)
            begin
                byte_pos_next     = '0;
                busy_next         = 1'b1;
                sat_flag_next     = 1'b0;
                length_sum_next   = igmplp_pkg::HDR_LEN;
                records_left_next = '0;
                record_start_next = '0;
                aux_words_next    = '0;
                count_high_next   = '0;
                kind_next         = igmplp_pkg::classify(stage_byte_reg);
                if (kind_next != igmplp_pkg::KIND_QUERY && kind_next != igmplp_pkg::KIND_V3)
                begin
                    emit = 1'b1;
                end
            end
            else if (busy_reg)
            begin
                byte_pos_next = pos_inc;
                if (kind_reg == igmplp_pkg::KIND_QUERY)
                begin
                    if (pos_inc == igmplp_pkg::POS_QCOUNT_HI)
                    begin
                        count_high_next = stage_byte_reg;
                    end
                    else if (pos_inc == igmplp_pkg::POS_QCOUNT_LO)
                    begin
                        if (sum_wide > {4'd0, igmplp_pkg::LEN_MAX})
                        begin
                            length_sum_next = igmplp_pkg::LEN_MAX;
                            sat_flag_next   = 1'b1;
                        end
                        else
                        begin
                            length_sum_next = sum_wide[LEN_W-1:0];
                        end
                        emit = 1'b1;
                    end
                end
                else
                begin
                    if (pos_inc == igmplp_pkg::POS_RCOUNT_HI)
                    begin
                        count_high_next = stage_byte_reg;
                    end
                    else if (pos_inc == igmplp_pkg::POS_RCOUNT_LO)
                    begin
                        records_left_next = count_word;
                        record_start_next = igmplp_pkg::POS_RECORDS;
                        if (count_word == 16'd0)
                        begin
                            emit = 1'b1;
                        end
                    end
                    else if (pos_inc >= igmplp_pkg::POS_RECORDS &&
                             pos_inc >= record_start_reg)
                    begin
                        if (rec_off == igmplp_pkg::OFF_AUX)
                        begin
                            aux_words_next = stage_byte_reg;
                        end
                        else if (rec_off == igmplp_pkg::OFF_NSRC_HI)
                        begin
                            count_high_next = stage_byte_reg;
                        end
                        else if (rec_off == igmplp_pkg::OFF_NSRC_LO)
                        begin
                            if (sum_wide > {4'd0, igmplp_pkg::LEN_MAX})
                            begin
                                // true length already past the limit
                                length_sum_next = igmplp_pkg::LEN_MAX;
                                sat_flag_next   = 1'b1;
                                emit            = 1'b1;
                            end
                            else
                            begin
                                length_sum_next   = sum_wide[LEN_W-1:0];
                                record_start_next = record_start_reg + rec_size[POS_W-1:0];
                                records_left_next = records_dec;
                                if (records_dec == 16'd0)
                                begin
                                    emit = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            if (emit)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            byte_pos_reg     <= '0;
            kind_reg         <= igmplp_pkg::KIND_V1;
            busy_reg         <= 1'b0;
            records_left_reg <= '0;
            record_start_reg <= '0;
            aux_words_reg    <= '0;
            count_high_reg   <= '0;
            length_sum_reg   <= '0;
            sat_flag_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (msg.valid && msg.ready)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (consume)
            begin
                stage_valid_reg <= 1'b0;
            end

            byte_pos_reg     <= byte_pos_next;
            kind_reg         <= kind_next;
            busy_reg         <= busy_next;
            records_left_reg <= records_left_next;
            record_start_reg <= record_start_next;
            aux_words_reg    <= aux_words_next;
            count_high_reg   <= count_high_next;
            length_sum_reg   <= length_sum_next;
            sat_flag_reg     <= sat_flag_next;

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (msg.valid && msg.ready)
        begin
            stage_byte_reg  <= msg.data_byte;
            stage_start_reg <= msg.msg_start;
        end
        if (emit)
        begin
            out_kind_reg   <= kind_next;
            out_length_reg <= length_sum_next;
            out_sat_reg    <= sat_flag_next;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.msg_kind         = out_kind_reg;
    assign result.msg_length       = out_length_reg;
    assign result.length_saturated = out_sat_reg;

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Byte stream test of the IGMP message length parser core. Directed and
// random IGMP messages are driven one word per handshake; an in-bench model
// predicts each length report, and a monitor checks every report field by
// field while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int POS_W = igmplp_pkg::POS_W;
    localparam int LEN_W = igmplp_pkg::LEN_W;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_CYCLES = 10;
    localparam int TOTAL_WORDS  = 950;
    localparam int GROUP_HDR    = 8;

    typedef struct packed {
        igmplp_pkg::kind_t kind;
        logic [LEN_W-1:0]  length;
        logic              saturated;
    } length_report_t;

    logic clk = 1'b0;
    logic rst_n;

    igmplp_in_if  msg_if ();
    igmplp_out_if res_if ();

    igmp_message_length_parser_core dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_if),
        .result (res_if)
    );

    always #6 clk = ~clk;

    // parser model state, starts as after reset
    logic [POS_W-1:0]  cur_pos     = '0;
    igmplp_pkg::kind_t cur_kind    = igmplp_pkg::KIND_V1;
    logic              parsing     = 1'b0;
    logic [15:0]       groups_left = '0;
    logic [POS_W-1:0]  group_base  = '0;
    logic [7:0]        group_aux   = '0;
    logic [7:0]        count_msb   = '0;
    logic [16:0]       run_len     = '0;
    logic              run_sat     = 1'b0;

    length_report_t expected_lengths [$];
    logic [7:0]     frame_bytes [$];

    int error_count  = 0;
    int sent_words   = 0;
    int cycle_count  = 0;
    bit sender_eager = 1'b0;
    bit sink_eager   = 1'b0;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // length model
    // ------------------------------------------------------------------
    function automatic igmplp_pkg::kind_t type_to_kind(input logic [7:0] type_byte);
        case (type_byte)
            igmplp_pkg::TYPE_V1_REPORT: return igmplp_pkg::KIND_V1;
            igmplp_pkg::TYPE_V2_REPORT: return igmplp_pkg::KIND_V2;
            igmplp_pkg::TYPE_LEAVE:     return igmplp_pkg::KIND_LEAVE;
            igmplp_pkg::TYPE_QUERY:     return igmplp_pkg::KIND_QUERY;
            igmplp_pkg::TYPE_V3_REPORT: return igmplp_pkg::KIND_V3;
            default:                    return igmplp_pkg::KIND_OTHER;
        endcase
    endfunction

    function automatic void report_length();
        expected_lengths.push_back(length_report_t'{kind: cur_kind,
                                                    length: run_len[LEN_W-1:0],
                                                    saturated: run_sat});
        parsing = 1'b0;
    endfunction

    function automatic void grow_length(input int unsigned add);
        int unsigned sum;
        sum = run_len + add;
        if (sum > igmplp_pkg::LEN_MAX)
        begin
            sum     = igmplp_pkg::LEN_MAX;
            run_sat = 1'b1;
        end
        run_len = 17'(sum);
    endfunction

    // advances the model by one accepted word
    function automatic void predict_word(input logic [7:0] b, input logic st);
        logic [POS_W-1:0] off;
        int unsigned      nsrc;
        int unsigned      size;
        if (st)
        begin
            cur_pos     = '0;
            parsing     = 1'b1;
            run_sat     = 1'b0;
            run_len     = 17'(igmplp_pkg::HDR_LEN);
            groups_left = '0;
            group_base  = '0;
            group_aux   = '0;
            count_msb   = '0;
            cur_kind    = type_to_kind(b);
            if (cur_kind != igmplp_pkg::KIND_QUERY && cur_kind != igmplp_pkg::KIND_V3)
                report_length();
            return;
        end
        if (!parsing)
            return;
        if (cur_pos != igmplp_pkg::POS_MAX)
            cur_pos++;
        if (cur_kind == igmplp_pkg::KIND_QUERY)
        begin
            if (cur_pos == igmplp_pkg::POS_QCOUNT_HI)
                count_msb = b;
            else if (cur_pos == igmplp_pkg::POS_QCOUNT_LO)
            begin
                grow_length(4 * int'({count_msb, b}));
                report_length();
            end
            return;
        end
        if (cur_pos == igmplp_pkg::POS_RCOUNT_HI)
            count_msb = b;
        else if (cur_pos == igmplp_pkg::POS_RCOUNT_LO)
        begin
            groups_left = {count_msb, b};
            group_base  = igmplp_pkg::POS_RECORDS;
            if (groups_left == 0)
                report_length();
        end
        else if (cur_pos >= igmplp_pkg::POS_RECORDS && cur_pos >= group_base)
        begin
            off = cur_pos - group_base;
            if (off == igmplp_pkg::OFF_AUX)
                group_aux = b;
            else if (off == igmplp_pkg::OFF_NSRC_HI)
                count_msb = b;
            else if (off == igmplp_pkg::OFF_NSRC_LO)
            begin
                nsrc = {count_msb, b};
                size = GROUP_HDR + 4 * group_aux + 4 * nsrc;
                grow_length(size);
                if (run_sat)
                    report_length();
                else
                begin
                    group_base = POS_W'(group_base + size);
                    groups_left--;
                    if (groups_left == 0)
                        report_length();
                end
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // message builders
    // ------------------------------------------------------------------
    function automatic void add_noise(input int n);
        repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void start_frame(input logic [7:0] type_byte);
        frame_bytes.delete();
        frame_bytes.push_back(type_byte);
    endfunction

    function automatic void build_query(input logic [15:0] sources);
        start_frame(igmplp_pkg::TYPE_QUERY);
        add_noise(9);
        frame_bytes.push_back(sources[15:8]);
        frame_bytes.push_back(sources[7:0]);
        add_noise($urandom_range(0, 3));
    endfunction

    function automatic void build_v3_header(input logic [15:0] groups);
        start_frame(igmplp_pkg::TYPE_V3_REPORT);
        add_noise(5);
        frame_bytes.push_back(groups[15:8]);
        frame_bytes.push_back(groups[7:0]);
    endfunction

    // the last group carries only a short tail, the report is out by then
    function automatic void add_group(input logic [7:0] aux, input logic [15:0] nsrc,
                                      input bit last);
        add_noise(1);
        frame_bytes.push_back(aux);
        frame_bytes.push_back(nsrc[15:8]);
        frame_bytes.push_back(nsrc[7:0]);
        if (last)
            add_noise($urandom_range(0, 3));
        else
            add_noise(4 + 4 * aux + 4 * nsrc);
    endfunction

    function automatic void build_random_query();
        if ($urandom_range(0, 7) == 0)
            build_query(16'($urandom_range(0, 65535)));
        else
            build_query(16'($urandom_range(0, 20)));
    endfunction

    function automatic void build_random_v3();
        int sel;
        int n;
        sel = $urandom_range(0, 7);
        if (sel == 0)
        begin
            build_v3_header(16'd0);
            add_noise($urandom_range(0, 3));
        end
        else if (sel == 1)
        begin
            // huge group count, first group already saturates
            build_v3_header(16'($urandom_range(1, 65535)));
            add_group(8'($urandom_range(0, 255)),
                      16'($urandom_range(16'h4000, 16'hFFFF)), 1'b1);
        end
        else
        begin
            n = $urandom_range(1, 4);
            build_v3_header(16'(n));
            for (int i = 0; i < n; i++)
                add_group(($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                                       : 8'($urandom_range(0, 2)),
                          ($urandom_range(0, 15) == 0) ? 16'($urandom_range(0, 255))
                                                       : 16'($urandom_range(0, 3)),
                          i == n - 1);
        end
    endfunction

    // ------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------
    task automatic send_word(input logic [7:0] b, input logic st);
        int gap;
        gap = sender_eager ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            msg_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        msg_if.valid     <= 1'b1;
        msg_if.data_byte <= b;
        msg_if.msg_start <= st;
        do @(posedge clk); while (msg_if.ready !== 1'b1);
        sent_words++;
        predict_word(b, st);
    endtask

    task automatic send_frame(input int keep);
        int n;
        n = (keep < frame_bytes.size()) ? keep : frame_bytes.size();
        for (int i = 0; i < n; i++)
            send_word(frame_bytes[i], i == 0);
    endtask

    task automatic wait_reports_done();
        while (expected_lengths.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_idle_words();
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(igmplp_pkg::TYPE_QUERY, 1'b0);
    endtask

    task automatic test_type_bytes();
        logic [7:0] types [8];
        types = '{igmplp_pkg::TYPE_V1_REPORT, igmplp_pkg::TYPE_V2_REPORT,
                  igmplp_pkg::TYPE_LEAVE, 8'h00, 8'hFF, 8'h02, 8'h07, 8'h21};
        foreach (types[i])
        begin
            start_frame(types[i]);
            if (i == 0)
                add_noise(2);
            send_frame(frame_bytes.size());
        end
    endtask

    task automatic test_query_lengths();
        build_query(16'h0000);
        send_frame(frame_bytes.size());
        // largest count that still fits, then the first that does not
        build_query(16'h3FFD);
        send_frame(frame_bytes.size());
        build_query(16'h3FFE);
        send_frame(frame_bytes.size());
        build_query(16'hFFFF);
        send_frame(frame_bytes.size());
    endtask

    task automatic test_v3_reports();
        build_v3_header(16'd0);
        send_frame(frame_bytes.size());
        build_v3_header(16'd2);
        add_group(8'd1, 16'd2, 1'b0);
        add_group(8'd0, 16'd0, 1'b1);
        send_frame(frame_bytes.size());
    endtask

    task automatic test_restart();
        build_query(16'd5);
        send_frame(11);
        build_v3_header(16'd1);
        add_group(8'd0, 16'd1, 1'b1);
        send_frame(10);
        build_v3_header(16'd1);
        add_group(8'd0, 16'd1, 1'b1);
        send_frame(frame_bytes.size());
    endtask

    task automatic test_saturation();
        wait_reports_done();
        sender_eager = 1'b1;
        // saturates on the second group after a first one that fits
        build_v3_header(16'hFFFF);
        add_group(8'h10, 16'd20, 1'b0);
        add_group(8'h00, 16'hFFFF, 1'b1);
        send_frame(frame_bytes.size());
        build_v3_header(16'd1);
        add_group(8'hFF, 16'hFFFF, 1'b1);
        send_frame(frame_bytes.size());
        sender_eager = 1'b0;
    endtask

    task automatic test_random_traffic();
        int sel;
        while (sent_words < TOTAL_WORDS)
        begin
            sender_eager = ($urandom_range(0, 3) == 0);
            sel = $urandom_range(0, 19);
            if (sel <= 2)
            begin
                case ($urandom_range(0, 5))
                    0: start_frame(igmplp_pkg::TYPE_V1_REPORT);
                    1: start_frame(igmplp_pkg::TYPE_V2_REPORT);
                    2: start_frame(igmplp_pkg::TYPE_LEAVE);
                    default: start_frame(8'($urandom_range(0, 255)));
                endcase
                add_noise($urandom_range(0, 3));
                send_frame(frame_bytes.size());
            end
            else if (sel <= 7)
            begin
                build_random_query();
                send_frame(frame_bytes.size());
            end
            else if (sel <= 15)
            begin
                build_random_v3();
                send_frame(frame_bytes.size());
            end
            else if (sel <= 17)
            begin
                // broken message, the next start word cuts it off
                if ($urandom_range(0, 1) == 0)
                    build_random_query();
                else
                    build_random_v3();
                send_frame($urandom_range(1, frame_bytes.size()));
            end
            else
            begin
                repeat ($urandom_range(1, 5))
                    send_word(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
            end
        end
        sender_eager = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // result monitor
    // ------------------------------------------------------------------
    initial
    begin : result_monitor
        int             stall;
        length_report_t want;
        res_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                sink_eager = !sink_eager;
            stall = sink_eager ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge clk); while (res_if.valid !== 1'b1);
            if (expected_lengths.size() == 0)
            begin
                $display("%0t: unexpected word: kind %0d length %0d saturated %0b",
                         $time, res_if.msg_kind, res_if.msg_length,
                         res_if.length_saturated);
                error_count++;
            end
            else
            begin
                want = expected_lengths.pop_front();
                if (res_if.msg_kind !== want.kind)
                begin
                    $display("%0t: msg_kind expected %0d actual %0d",
                             $time, want.kind, res_if.msg_kind);
                    error_count++;
                end
                if (res_if.msg_length !== want.length)
                begin
                    $display("%0t: msg_length expected %0d actual %0d",
                             $time, want.length, res_if.msg_length);
                    error_count++;
                end
                if (res_if.length_saturated !== want.saturated)
                begin
                    $display("%0t: length_saturated expected %0b actual %0b",
                             $time, want.saturated, res_if.length_saturated);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n            = 1'b0;
        msg_if.valid     = 1'b0;
        msg_if.data_byte = 8'h00;
        msg_if.msg_start = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_idle_words();
        test_type_bytes();
        test_query_lengths();
        test_v3_reports();
        test_restart();
        test_saturation();
        test_random_traffic();

        msg_if.valid <= 1'b0;
        wait_reports_done();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
